// ===== src/kdim_pkg.sv =====
// ----------------------------------------------------------------------------
// kdim_pkg: shared constants and types of the key to dense index map
// Sizes of the key store and slot table, status and operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdim_pkg;

  // Storage sizes
  localparam int CAPACITY = 1024;
  localparam int SLOTS    = 2048;
  localparam int KEY_W    = 64;

  // Derived widths
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ID_W   = $clog2(CAPACITY);
  localparam int IDX_W  = $clog2(CAPACITY + 1);

  // Derived compare constants
  localparam logic [IDX_W-1:0]  CAP_X     = IDX_W'(CAPACITY);
  localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_ZERO = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

endpackage : kdim_pkg

`default_nettype wire

// ===== src/kdim_ram.sv =====
// ----------------------------------------------------------------------------
// kdim_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : kdim_ram

`default_nettype wire

// ===== src/kdim_hash.sv =====
// ----------------------------------------------------------------------------
// kdim_hash: home slot of a key
// Mixes the key, folds it by XOR to the slot width and wraps into range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdim_hash
  import kdim_pkg::*;
(
  input  wire logic [KEY_W-1:0]  key,
  output      logic [SLOT_W-1:0] slot
);

  localparam int NCHUNK = (KEY_W + SLOT_W - 1) / SLOT_W;

  logic [KEY_W-1:0]  mix;
  logic [SLOT_W-1:0] fold;

  // Fold the mixed key into one slot-wide word
  always_comb begin
    mix  = key ^ (key >> 29) ^ (key << 17);
    fold = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      fold = fold ^ mix[SLOT_W-1:0];
      mix  = mix >> SLOT_W;
    end
  end

  // Wrap into the table when the slot count is not a power of two
  always_comb begin
    if ({1'b0, fold} >= SLOTS_X) begin
      slot = fold - SLOTS_X[SLOT_W-1:0];
    end else begin
      slot = fold;
    end
  end

endmodule : kdim_hash

`default_nettype wire

// ===== src/key_to_dense_index_map_unit.sv =====
// ----------------------------------------------------------------------------
// key_to_dense_index_map_unit: 64-bit key to dense id map
// Open-addressed slot table with linear probing over a key store by id.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_op, in_key) arrive on a valid/ready channel. An insert
//   gives a new key the next id; the result word carries found, the 1-based
//   index and a status (ok, duplicate, zero key, table full). A lookup
//   returns found and the 1-based index, or zero on a miss.
//   One word is worked at a time; in_ready is high only while idle.
//   An occupied slot takes a registered read of the slot table, then a
//   registered read of the key store for the compare; an empty slot ends
//   the probe after its slot read. A zero key skips the probe and goes
//   straight to the result. in_ready returns together with out_valid, as
//   the result is loaded into the output register.
//   After reset the slot table is cleared, one slot a cycle, over all 2048
//   slots; in_ready stays low during that pass.
//   The result sits in an output register. A new word is accepted while it
//   waits; when out_ready stays low, the next finished result holds in the
//   core until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_to_dense_index_map_unit
  import kdim_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic             in_op,
  input  wire logic [KEY_W-1:0] in_key,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic             out_found,
  output      logic [IDX_W-1:0] out_index,
  output      logic [1:0]       out_status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_CHK,
    S_KEY_CHK,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] probes_r, probes_nxt;
  logic [IDX_W-1:0]  val_r, val_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  op_t               op_r, op_nxt;
  logic              res_found_r, res_found_nxt;
  logic [IDX_W-1:0]  res_index_r, res_index_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  status_t           out_status_r, out_status_nxt;

  logic [SLOT_W-1:0] home_slot;
  logic [SLOT_W-1:0] next_slot;
  logic              circuit_done;

  logic              st_we, st_re;
  logic [SLOT_W-1:0] st_waddr, st_raddr;
  logic [IDX_W-1:0]  st_wdata, st_rdata;
  logic              ks_we, ks_re;
  logic [ID_W-1:0]   ks_waddr, ks_raddr;
  logic [KEY_W-1:0]  ks_rdata;
  logic [IDX_W-1:0]  val_m1;

  kdim_hash u_hash (
    .key  (in_key),
    .slot (home_slot)
  );

  kdim_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_slot_table (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  kdim_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk   (clk),
    .we    (ks_we),
    .waddr (ks_waddr),
    .wdata (key_r),
    .re    (ks_re),
    .raddr (ks_raddr),
    .rdata (ks_rdata)
  );

  // Next probe position and end of a full circuit
  assign next_slot    = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign circuit_done = (probes_r == LAST_SLOT);
  assign val_m1       = st_rdata - 1'b1;
  assign ks_waddr     = count_r[ID_W-1:0];

  // Sequencer: one probe step at a time over the shared slot and key reads
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    probes_nxt     = probes_r;
    val_nxt        = val_r;
    key_nxt        = key_r;
    op_nxt         = op_r;
    res_found_nxt  = res_found_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;

    st_we    = 1'b0;
    st_waddr = slot_r;
    st_wdata = count_r + 1'b1;
    st_re    = 1'b0;
    st_raddr = next_slot;
    ks_we    = 1'b0;
    ks_re    = 1'b0;
    ks_raddr = val_m1[ID_W-1:0];

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          key_nxt       = in_key;
          op_nxt        = op_t'(in_op);
          slot_nxt      = home_slot;
          probes_nxt    = '0;
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          if (in_key == '0) begin
            res_status_nxt = (op_t'(in_op) == OP_INSERT) ? ST_ZERO : ST_OK;
            state_nxt      = S_RESP;
          end else begin
            res_status_nxt = ST_OK;
            st_re          = 1'b1;
            st_raddr       = home_slot;
            state_nxt      = S_SLOT_CHK;
          end
        end
      end

      S_SLOT_CHK: begin
        val_nxt = st_rdata;
        if (st_rdata == '0) begin
          // Empty slot: miss, insert here if room is left
          if (op_r == OP_INSERT) begin
            if (count_r >= CAP_X) begin
              res_status_nxt = ST_FULL;
            end else begin
              st_we          = 1'b1;
              ks_we          = 1'b1;
              count_nxt      = count_r + 1'b1;
              res_found_nxt  = 1'b1;
              res_index_nxt  = count_r + 1'b1;
            end
          end
          state_nxt = S_RESP;
        end else if (st_rdata <= CAP_X) begin
          ks_re     = 1'b1;
          state_nxt = S_KEY_CHK;
        end else if (circuit_done) begin
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_FULL;
          end
          state_nxt = S_RESP;
        end else begin
          // Skip an id that names no entry
          st_re      = 1'b1;
          slot_nxt   = next_slot;
          probes_nxt = probes_r + 1'b1;
        end
      end

      S_KEY_CHK: begin
        if (ks_rdata == key_r) begin
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_DUP;
          end else begin
            res_found_nxt = 1'b1;
            res_index_nxt = val_r;
          end
          state_nxt = S_RESP;
        end else if (circuit_done) begin
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_FULL;
          end
          state_nxt = S_RESP;
        end else begin
          // Advance to the next slot
          st_re      = 1'b1;
          slot_nxt   = next_slot;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_SLOT_CHK;
        end
      end

      S_RESP: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_index_nxt  = res_index_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r       <= slot_nxt;
    probes_r     <= probes_nxt;
    val_r        <= val_nxt;
    key_r        <= key_nxt;
    op_r         <= op_nxt;
    res_found_r  <= res_found_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

endmodule : key_to_dense_index_map_unit

`default_nettype wire
